// ===== rtl/biou_pkg.sv =====
// ----------------------------------------------------------------------------
// biou_pkg
// Shared constants and helpers for the box overlap ratio pipeline.
// ----------------------------------------------------------------------------
package biou_pkg;

  // default coordinate and fraction widths
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // widest coordinate the helpers take
  localparam int MAX_COORD_BITS = 16;

  typedef logic [MAX_COORD_BITS-1:0] coord_t;
  typedef logic [MAX_COORD_BITS:0]   span_t;

  // inclusive span length, zero when empty
  function automatic span_t span_len(coord_t lo, coord_t hi);
    span_t res;
    if (hi >= lo) begin
      res = {1'b0, hi} - {1'b0, lo} + span_t'(1);
    end else begin
      res = '0;
    end
    return res;
  endfunction

  function automatic coord_t max_c(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t min_c(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/biou_front.sv =====
// ----------------------------------------------------------------------------
// biou_front
// Three-stage front end: spans and validity, areas, then union.
// ----------------------------------------------------------------------------
module biou_front #(
  parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // upstream item
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [COORD_BITS-1:0]   px0,
  input  logic [COORD_BITS-1:0]   py0,
  input  logic [COORD_BITS-1:0]   px1,
  input  logic [COORD_BITS-1:0]   py1,
  input  logic [COORD_BITS-1:0]   rx0,
  input  logic [COORD_BITS-1:0]   ry0,
  input  logic [COORD_BITS-1:0]   rx1,
  input  logic [COORD_BITS-1:0]   ry1,
  // downstream item: intersection, union, forced-zero flag
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [2*COORD_BITS+1:0] dn_inter,
  output logic [2*COORD_BITS+1:0] dn_union,
  output logic                    dn_inv
);

  localparam int SW = COORD_BITS + 1;     // span width
  localparam int AW = 2 * COORD_BITS + 1; // area width
  localparam int UW = 2 * COORD_BITS + 2; // union width

  logic          v1_r, v2_r, v3_r;
  logic          rdy1, rdy2, rdy3;
  logic [SW-1:0] sxp_r, syp_r, sxr_r, syr_r, sxi_r, syi_r;
  logic          inv1_r, inv2_r, inv3_r;
  logic [AW-1:0] ap_r, ar_r, ai_r;
  logic [UW-1:0] uni_r, inter_r;
  logic [UW-1:0] uni_nxt;

  // bubble-collapsing ready chain
  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1: per-axis spans and box validity
  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      sxp_r  <= SW'(biou_pkg::span_len(biou_pkg::coord_t'(px0), biou_pkg::coord_t'(px1)));
      syp_r  <= SW'(biou_pkg::span_len(biou_pkg::coord_t'(py0), biou_pkg::coord_t'(py1)));
      sxr_r  <= SW'(biou_pkg::span_len(biou_pkg::coord_t'(rx0), biou_pkg::coord_t'(rx1)));
      syr_r  <= SW'(biou_pkg::span_len(biou_pkg::coord_t'(ry0), biou_pkg::coord_t'(ry1)));
      sxi_r  <= SW'(biou_pkg::span_len(
                  biou_pkg::max_c(biou_pkg::coord_t'(px0), biou_pkg::coord_t'(rx0)),
                  biou_pkg::min_c(biou_pkg::coord_t'(px1), biou_pkg::coord_t'(rx1))));
      syi_r  <= SW'(biou_pkg::span_len(
                  biou_pkg::max_c(biou_pkg::coord_t'(py0), biou_pkg::coord_t'(ry0)),
                  biou_pkg::min_c(biou_pkg::coord_t'(py1), biou_pkg::coord_t'(ry1))));
      inv1_r <= (px0 > px1) || (py0 > py1) || (rx0 > rx1) || (ry0 > ry1);
    end
  end

  // stage 2: three areas, one multiplier each
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      ap_r   <= AW'(sxp_r) * AW'(syp_r);
      ar_r   <= AW'(sxr_r) * AW'(syr_r);
      ai_r   <= AW'(sxi_r) * AW'(syi_r);
      inv2_r <= inv1_r;
    end
  end

  // stage 3: union and zero-union check
  assign uni_nxt = UW'(ap_r) + UW'(ar_r) - UW'(ai_r);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      uni_r   <= uni_nxt;
      inter_r <= UW'(ai_r);
      inv3_r  <= inv2_r || (uni_nxt == '0);
    end
  end

  assign dn_valid = v3_r;
  assign dn_inter = inter_r;
  assign dn_union = uni_r;
  assign dn_inv   = inv3_r;

endmodule

// ===== rtl/biou_div_cell.sv =====
// ----------------------------------------------------------------------------
// biou_div_cell
// One restoring-division cell: produces one quotient bit per item.
// ----------------------------------------------------------------------------
module biou_div_cell #(
  parameter int RW = 2 * biou_pkg::COORD_BITS_DEF + 2,
  parameter int QW = biou_pkg::FRAC_BITS_DEF + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  // upstream item
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [RW:0]   up_rem,
  input  logic [RW-1:0] up_div,
  input  logic [QW-1:0] up_quo,
  input  logic          up_inv,
  // downstream item
  output logic          dn_valid,
  input  logic          dn_ready,
  output logic [RW:0]   dn_rem,
  output logic [RW-1:0] dn_div,
  output logic [QW-1:0] dn_quo,
  output logic          dn_inv
);

  logic          valid_r;
  logic [RW:0]   rem_r;
  logic [RW-1:0] div_r;
  logic [QW-1:0] quo_r;
  logic          inv_r;
  logic          qbit;
  logic [RW:0]   diff;
  logic [RW:0]   rem_nxt;

  assign up_ready = !valid_r || dn_ready;

  // compare, subtract, shift left for the next bit
  always_comb begin
    qbit = (up_rem >= {1'b0, up_div});
    diff = up_rem - {1'b0, up_div};
    if (qbit) begin
      rem_nxt = {diff[RW-1:0], 1'b0};
    end else begin
      rem_nxt = {up_rem[RW-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_r <= rem_nxt;
      div_r <= up_div;
      quo_r <= {up_quo[QW-2:0], qbit};
      inv_r <= up_inv;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_div   = div_r;
  assign dn_quo   = quo_r;
  assign dn_inv   = inv_r;

endmodule

// ===== rtl/box_iou_fixed_point.sv =====
// ----------------------------------------------------------------------------
// box_iou_fixed_point
// Intersection over union of two axis-aligned boxes, fixed-point result.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | pred and ref box corners
//   out_    | output    | out_valid/out_stall | overlap_ratio, invalid_box
//
// One item per cycle sustained while out_stall is low. The pipeline is
// three front stages, then one division cell per quotient bit. Every
// stage holds its own valid bit, so bubbles collapse and input is taken
// while a result waits at the output, as long as some stage is empty.
// Reset (rst_n low, synchronous) empties all stages.
// ----------------------------------------------------------------------------
module box_iou_fixed_point #(
  parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = biou_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_pred_x_min,
  input  logic [COORD_BITS-1:0] in_pred_y_min,
  input  logic [COORD_BITS-1:0] in_pred_x_max,
  input  logic [COORD_BITS-1:0] in_pred_y_max,
  input  logic [COORD_BITS-1:0] in_ref_x_min,
  input  logic [COORD_BITS-1:0] in_ref_y_min,
  input  logic [COORD_BITS-1:0] in_ref_x_max,
  input  logic [COORD_BITS-1:0] in_ref_y_max,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FRAC_BITS:0]    out_overlap_ratio,
  output logic                  out_invalid_box
);

  localparam int RW    = 2 * COORD_BITS + 2; // union width
  localparam int QW    = FRAC_BITS + 1;      // quotient width
  localparam int NCELL = FRAC_BITS + 1;

  logic          in_ready;
  logic          f_valid, f_ready, f_inv;
  logic [RW-1:0] f_inter, f_union;

  logic          c_valid [0:NCELL];
  logic          c_ready [0:NCELL];
  logic [RW:0]   c_rem   [0:NCELL];
  logic [RW-1:0] c_div   [0:NCELL];
  logic [QW-1:0] c_quo   [0:NCELL];
  logic          c_inv   [0:NCELL];

  assign in_stall = !in_ready;

  // front end: spans, areas, union
  biou_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .px0      (in_pred_x_min),
    .py0      (in_pred_y_min),
    .px1      (in_pred_x_max),
    .py1      (in_pred_y_max),
    .rx0      (in_ref_x_min),
    .ry0      (in_ref_y_min),
    .rx1      (in_ref_x_max),
    .ry1      (in_ref_y_max),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_inter (f_inter),
    .dn_union (f_union),
    .dn_inv   (f_inv)
  );

  // head of the cell row: remainder starts as the intersection area
  assign c_valid[0] = f_valid;
  assign f_ready    = c_ready[0];
  assign c_rem[0]   = {1'b0, f_inter};
  assign c_div[0]   = f_union;
  assign c_quo[0]   = '0;
  assign c_inv[0]   = f_inv;

  // division cells, most significant quotient bit first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    biou_div_cell #(
      .RW(RW),
      .QW(QW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_rem   (c_rem[i]),
      .up_div   (c_div[i]),
      .up_quo   (c_quo[i]),
      .up_inv   (c_inv[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_rem   (c_rem[i+1]),
      .dn_div   (c_div[i+1]),
      .dn_quo   (c_quo[i+1]),
      .dn_inv   (c_inv[i+1])
    );
  end

  // last cell is the output register
  assign c_ready[NCELL]    = !out_stall;
  assign out_valid         = c_valid[NCELL];
  assign out_invalid_box   = c_inv[NCELL];
  assign out_overlap_ratio = c_inv[NCELL] ? '0 : c_quo[NCELL];

  // forced-zero results carry a zero ratio
  a_inv_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_invalid_box || out_overlap_ratio == '0))
    else $error("invalid item with nonzero ratio");

  // ratio never exceeds one
  a_ratio_max : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_overlap_ratio[FRAC_BITS] && (|out_overlap_ratio[FRAC_BITS-1:0])))
    else $error("ratio above one");

  // with the output register empty every stage can move, so input is open
  a_no_stall_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks box_iou_fixed_point against a cycle-free overlap-ratio predictor.
// Directed box pairs cover the corners of the pixel grid, full and empty
// overlap and each kind of invalid box. Random pairs then follow, mostly
// valid boxes placed near each other, plus noise. Both channels idle in
// random bursts. Each result is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CW       = biou_pkg::COORD_BITS_DEF;
  localparam int FW       = biou_pkg::FRAC_BITS_DEF;
  localparam int GRID     = 1 << CW;
  localparam int LATENCY  = 3 + FW + 1;
  localparam int LIMIT    = 400000;
  localparam int MAX_MSGS = 40;

  typedef logic [CW-1:0] pix_t;
  typedef logic [FW:0]   ratio_t;

  typedef struct packed {
    pix_t pred_x_min;
    pix_t pred_y_min;
    pix_t pred_x_max;
    pix_t pred_y_max;
    pix_t ref_x_min;
    pix_t ref_y_min;
    pix_t ref_x_max;
    pix_t ref_y_max;
  } box_pair_t;

  typedef struct packed {
    ratio_t ratio;
    logic   invalid;
  } overlap_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  pix_t   in_pred_x_min = '0;
  pix_t   in_pred_y_min = '0;
  pix_t   in_pred_x_max = '0;
  pix_t   in_pred_y_max = '0;
  pix_t   in_ref_x_min = '0;
  pix_t   in_ref_y_min = '0;
  pix_t   in_ref_x_max = '0;
  pix_t   in_ref_y_max = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  ratio_t out_overlap_ratio;
  logic   out_invalid_box;

  overlap_t pending_ratios[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       idle_on = 1'b1;
  int       n_pairs = 0;
  int       n_flagged = 0;
  int       n_full = 0;
  int       n_disjoint = 0;

  box_iou_fixed_point #(
    .COORD_BITS(CW),
    .FRAC_BITS (FW)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pred_x_min    (in_pred_x_min),
    .in_pred_y_min    (in_pred_y_min),
    .in_pred_x_max    (in_pred_x_max),
    .in_pred_y_max    (in_pred_y_max),
    .in_ref_x_min     (in_ref_x_min),
    .in_ref_y_min     (in_ref_y_min),
    .in_ref_x_max     (in_ref_x_max),
    .in_ref_y_max     (in_ref_y_max),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_overlap_ratio(out_overlap_ratio),
    .out_invalid_box  (out_invalid_box)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // inclusive span length, zero when empty
  function automatic logic [63:0] axis_len(pix_t lo, pix_t hi);
    return (hi >= lo) ? 64'(hi) - 64'(lo) + 64'd1 : 64'd0;
  endfunction

  // expected ratio and flag for one box pair
  function automatic overlap_t predict_overlap(box_pair_t b);
    logic [63:0] inter, area_p, area_r, uni, quot;
    overlap_t    r;
    r.ratio   = '0;
    r.invalid = 1'b1;
    if (b.pred_x_min > b.pred_x_max || b.pred_y_min > b.pred_y_max ||
        b.ref_x_min > b.ref_x_max || b.ref_y_min > b.ref_y_max) begin
      return r;
    end
    inter = axis_len((b.pred_x_min > b.ref_x_min) ? b.pred_x_min : b.ref_x_min,
                     (b.pred_x_max < b.ref_x_max) ? b.pred_x_max : b.ref_x_max) *
            axis_len((b.pred_y_min > b.ref_y_min) ? b.pred_y_min : b.ref_y_min,
                     (b.pred_y_max < b.ref_y_max) ? b.pred_y_max : b.ref_y_max);
    area_p = axis_len(b.pred_x_min, b.pred_x_max) * axis_len(b.pred_y_min, b.pred_y_max);
    area_r = axis_len(b.ref_x_min, b.ref_x_max) * axis_len(b.ref_y_min, b.ref_y_max);
    uni    = area_p + area_r - inter;
    // a zero union is flagged like an invalid box
    if (uni == 64'd0) begin
      return r;
    end
    quot      = (inter << FW) / uni;
    r.ratio   = quot[FW:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  function automatic box_pair_t make_pair(int px0, int py0, int px1, int py1,
                                          int rx0, int ry0, int rx1, int ry1);
    box_pair_t b;
    b.pred_x_min = pix_t'(px0);
    b.pred_y_min = pix_t'(py0);
    b.pred_x_max = pix_t'(px1);
    b.pred_y_max = pix_t'(py1);
    b.ref_x_min  = pix_t'(rx0);
    b.ref_y_min  = pix_t'(ry0);
    b.ref_x_max  = pix_t'(rx1);
    b.ref_y_max  = pix_t'(ry1);
    return b;
  endfunction

  // mostly small spans, a few reaching the whole grid
  function automatic int pick_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(1, 64);
    if (sel < 96) return $urandom_range(1, 1024);
    return $urandom_range(1, GRID);
  endfunction

  // span of given length that overlaps or just touches [rlo, rhi]
  function automatic void pick_near(input int rlo, input int rhi, input int len,
                                    output int lo, output int hi);
    int lo_min, lo_max;
    lo_min = (rlo > len) ? rlo - len : 0;
    lo_max = (rhi + 1 < GRID - len) ? rhi + 1 : GRID - len;
    lo = $urandom_range(lo_min, lo_max);
    hi = lo + len - 1;
  endfunction

  // report one mismatch, print a bounded number of lines
  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_count < MAX_MSGS) begin
      $display("mismatch at cycle %0d: %0s got %0d want %0d", cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  // send one box pair and record its prediction once accepted
  task automatic send_pair(box_pair_t b);
    overlap_t want;
    int       gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pred_x_min <= b.pred_x_min;
    in_pred_y_min <= b.pred_y_min;
    in_pred_x_max <= b.pred_x_max;
    in_pred_y_max <= b.pred_y_max;
    in_ref_x_min  <= b.ref_x_min;
    in_ref_y_min  <= b.ref_y_min;
    in_ref_x_max  <= b.ref_x_max;
    in_ref_y_max  <= b.ref_y_max;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_overlap(b);
    pending_ratios = {pending_ratios, want};
    n_pairs++;
    if (want.invalid) n_flagged++;
    else if (want.ratio == ratio_t'(1 << FW)) n_full++;
    else if (want.ratio == '0) n_disjoint++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    overlap_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ratios.size() == 0) begin
        report_mismatch("result with nothing pending", out_overlap_ratio, 0);
      end else begin
        want = pending_ratios.pop_front();
        if (out_overlap_ratio !== want.ratio)
          report_mismatch("overlap_ratio", out_overlap_ratio, want.ratio);
        if (out_invalid_box !== want.invalid)
          report_mismatch("invalid_box", out_invalid_box, want.invalid);
      end
    end
  end

  // receiver stall bursts
  initial begin : stall_bursts
    int n;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_ratios.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // grid corners, full and empty overlap, every invalid axis
  task automatic test_directed();
    int m;
    m = GRID - 1;
    send_pair(make_pair(0, 0, m, m, 0, 0, m, m));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(m, m, m, m, m, m, m, m));
    send_pair(make_pair(0, 0, 0, 0, m, m, m, m));
    send_pair(make_pair(0, 0, m, m, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, m, m, m, m, m, m));
    send_pair(make_pair(10, 10, 19, 19, 20, 10, 29, 19));
    send_pair(make_pair(10, 10, 20, 19, 20, 10, 29, 19));
    send_pair(make_pair(0, 0, 9, 9, 0, 20, 9, 29));
    send_pair(make_pair(100, 100, 199, 199, 150, 150, 249, 249));
    send_pair(make_pair(0, 0, 99, 99, 25, 25, 74, 74));
    send_pair(make_pair(0, 0, 2, 0, 1, 0, 3, 0));
    // invalid pred x, pred y, ref x, ref y, and both boxes
    send_pair(make_pair(m, 0, 0, m, 0, 0, m, m));
    send_pair(make_pair(0, m, m, 0, 0, 0, m, m));
    send_pair(make_pair(0, 0, m, m, 1, 0, 0, m));
    send_pair(make_pair(0, 0, m, m, 0, 1, m, 0));
    send_pair(make_pair(m, m, 0, 0, m, m, 0, 0));
    send_pair(make_pair(5, 5, 4, 9, 5, 5, 9, 9));
  endtask

  // valid boxes near each other, some identical, a few broken
  task automatic test_near_boxes(int count);
    int rx0, rx1, ry0, ry1, px0, px1, py0, py1, t;
    box_pair_t b;
    repeat (count) begin
      t = pick_len();
      rx0 = $urandom_range(0, GRID - t);
      rx1 = rx0 + t - 1;
      t = pick_len();
      ry0 = $urandom_range(0, GRID - t);
      ry1 = ry0 + t - 1;
      if ($urandom_range(0, 19) == 0) begin
        px0 = rx0; px1 = rx1; py0 = ry0; py1 = ry1;
      end else begin
        pick_near(rx0, rx1, pick_len(), px0, px1);
        pick_near(ry0, ry1, pick_len(), py0, py1);
      end
      b = make_pair(px0, py0, px1, py1, rx0, ry0, rx1, ry1);
      // swap one axis to break a box now and then
      case ($urandom_range(0, 39))
        0: begin b.pred_x_min = pix_t'(px1); b.pred_x_max = pix_t'(px0); end
        1: begin b.pred_y_min = pix_t'(py1); b.pred_y_max = pix_t'(py0); end
        2: begin b.ref_x_min = pix_t'(rx1); b.ref_x_max = pix_t'(rx0); end
        3: begin b.ref_y_min = pix_t'(ry1); b.ref_y_max = pix_t'(ry0); end
        default: ;
      endcase
      send_pair(b);
    end
  endtask

  // fully random corners, mostly invalid boxes
  task automatic test_noise(int count);
    box_pair_t b;
    repeat (count) begin
      b = box_pair_t'({$urandom(), $urandom(), $urandom()});
      send_pair(b);
    end
  endtask

  // sender holds off until every pending result is back
  task automatic test_drain_pause();
    test_near_boxes(30);
    in_valid <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk);
    test_near_boxes(30);
  endtask

  // back to back items with no idling on either side
  task automatic test_no_idle(int count);
    idle_on = 1'b0;
    test_near_boxes(count);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_near_boxes(650);
    test_noise(250);
    test_drain_pause();
    test_near_boxes(250);
    test_no_idle(200);
    in_valid <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    $display("covered %0d box pairs in %0d cycles with idling on both channels",
             n_pairs, cycle_count);
    $display("  %0d flagged invalid, %0d full overlap, %0d valid with zero ratio",
             n_flagged, n_full, n_disjoint);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
